/* rtl/llch_pkg.sv */
package llch_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam int unsigned DVD_W = 64;
  localparam int unsigned DVS_W = 32;

  typedef struct packed {
    logic start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/llch_div.sv */
module llch_div (
  input  logic               clk,
  input  logic               rst,
  input  llch_pkg::div_req_t req,
  output llch_pkg::div_rsp_t rsp
);
  import llch_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic             fin;
  logic [DVS_W:0]   rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem[DVS_W-1:0], quo[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign rsp = {fin, quo};

endmodule

/* rtl/log_linear_cost_histogram_core.sv */
// Log-linear cost histogram. Items on s_tdata are commands: add a sample, query,
// or clear. Bucket counters live in a single-port-read/single-port-write memory of
// LINEAR_BUCKETS+GEOMETRIC_BUCKETS words. After reset and after every clear the
// block sweeps the memory, one word per cycle, with s_tready low. An add steps
// through accept, locate, read and write back, and skips the write back when the
// sample lands in overflow. A query sets up its target, reads and checks each
// bucket scanned (the running count is kept scaled by 1000, so the rank check
// needs no division), works out the bucket bounds when a bucket is found, and
// runs one 64-step restoring division for the mean; with no samples it skips
// the scan and the division. One query result is held on m_tdata until taken.
module log_linear_cost_histogram_core #(
  parameter int unsigned LINEAR_BUCKETS    = 64,
  parameter int unsigned GEOMETRIC_BUCKETS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[1:0], sample_ticks[33:2], quantile_permille[43:34], zero pad
  input  logic [47:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // quantile_value, quantile_exact, quantile_bucket_width, mean_ticks,
  // min_ticks, max_ticks, sample_count, overflow_count, zero pad
  output logic [207:0] m_tdata
);
  import llch_pkg::*;

  localparam int unsigned TOTAL = LINEAR_BUCKETS + GEOMETRIC_BUCKETS;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned ACC_W = 32 + AW + 11;
  localparam logic [31:0] ONES  = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_ADD_LOC, ST_ADD_RD, ST_ADD_WR,
    ST_Q_MUL, ST_Q_TGT, ST_SCAN_RD, ST_SCAN_CHK,
    ST_Q_BND, ST_Q_MEAN, ST_Q_MWAIT, ST_Q_OUT
  } state_t;

  state_t state, state_next;

  logic [31:0] mem [TOTAL];
  logic [31:0] rdata;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;

  cmd_t        cmd;
  logic [31:0] in_v;
  logic [9:0]  in_pm;
  logic        acc_in;

  logic [31:0] min_seen, max_seen, samples_seen, overflow_seen;
  logic [63:0] sample_sum;

  logic [31:0] v;
  logic [9:0]  pm;
  logic [4:0]  shf;
  logic [AW-1:0] idx, bidx;
  logic [41:0] prod;
  logic [41:0] target;
  logic [ACC_W-1:0] acc;
  logic [31:0] qv, mean;
  logic        qe;
  logic [7:0]  qw;

  div_req_t dreq;
  div_rsp_t drsp;

  assign cmd    = cmd_t'(s_tdata[1:0]);
  assign in_v   = s_tdata[33:2];
  assign in_pm  = s_tdata[43:34];
  assign s_tready = (state == ST_IDLE);
  assign acc_in = s_tvalid && s_tready;

  llch_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // locate: msb of ((v-L)>>3)+1 gives the shift
  logic [31:0] d;
  logic [29:0] qd;
  logic [4:0]  s_raw;
  always_comb begin
    d     = v - 32'(LINEAR_BUCKETS);
    qd    = 30'(d >> 3) + 30'd1;
    s_raw = '0;
    for (int i = 0; i < 30; i++) begin
      if (qd[i]) s_raw = 5'(i);
    end
  end

  logic [32:0] base;
  logic [31:0] goff, gidx;
  logic        ovf, is_lin;
  always_comb begin
    base   = (33'd8 << shf) - 33'd8;
    goff   = 32'((33'(d) - base) >> shf);
    gidx   = 32'(shf) * 32'd8 + goff;
    is_lin = v < 32'(LINEAR_BUCKETS);
    ovf    = !is_lin && (gidx >= 32'(GEOMETRIC_BUCKETS));
  end

  // bucket bounds
  logic [31:0] fg;
  logic [4:0]  fs;
  logic [63:0] lo, hi, w64;
  always_comb begin
    fg  = 32'(idx) - 32'(LINEAR_BUCKETS);
    fs  = (fg >> 3) > 32'd20 ? 5'd20 : 5'(fg >> 3);
    w64 = 64'd1 << fs;
    lo  = 64'(LINEAR_BUCKETS) + (64'd8 << fs) - 64'd8
        + (64'(fg - 32'(fs) * 32'd8) << fs);
    hi  = lo + w64 - 64'd1;
  end

  // running count times 1000, compared against count * permille
  logic [ACC_W-1:0] rd_ext, acc_n;
  assign rd_ext = ACC_W'(rdata);
  assign acc_n  = acc + (rd_ext << 10) - (rd_ext << 4) - (rd_ext << 3);

  always_comb begin
    state_next    = state;
    rd_en         = 1'b0;
    rd_addr       = idx;
    wr_en         = 1'b0;
    wr_addr       = idx;
    wr_data       = '0;
    dreq.start    = 1'b0;
    dreq.dividend = sample_sum;
    dreq.divisor  = samples_seen;
    case (state)
      ST_CLR: begin
        wr_en = 1'b1;
        if (idx == AW'(TOTAL - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc_in) begin
          case (cmd)
            CMD_ADD:   state_next = ST_ADD_LOC;
            CMD_QUERY: state_next = ST_Q_MUL;
            CMD_CLEAR: state_next = ST_CLR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_LOC: state_next = ST_ADD_RD;
      ST_ADD_RD: begin
        rd_en      = !ovf;
        rd_addr    = is_lin ? AW'(v) : AW'(32'(LINEAR_BUCKETS) + gidx);
        state_next = ovf ? ST_IDLE : ST_ADD_WR;
      end
      ST_ADD_WR: begin
        wr_en      = 1'b1;
        wr_addr    = bidx;
        wr_data    = (rdata == ONES) ? rdata : rdata + 32'd1;
        state_next = ST_IDLE;
      end
      ST_Q_MUL: state_next = (samples_seen == '0) ? ST_Q_OUT : ST_Q_TGT;
      ST_Q_TGT: state_next = ST_SCAN_RD;
      ST_SCAN_RD: begin
        rd_en      = 1'b1;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (acc_n >= ACC_W'(target)) state_next = ST_Q_BND;
        else if (idx == AW'(TOTAL - 1)) state_next = ST_Q_MEAN;
        else state_next = ST_SCAN_RD;
      end
      ST_Q_BND: state_next = ST_Q_MEAN;
      ST_Q_MEAN: begin
        dreq.start = 1'b1;
        state_next = ST_Q_MWAIT;
      end
      ST_Q_MWAIT: if (drsp.done) state_next = ST_Q_OUT;
      ST_Q_OUT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (state == ST_Q_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen      <= ONES;
      max_seen      <= '0;
      samples_seen  <= '0;
      sample_sum    <= '0;
      overflow_seen <= '0;
      idx           <= '0;
    end else begin
      case (state)
        ST_CLR: idx <= idx + 1'b1;
        ST_IDLE: begin
          if (acc_in) begin
            v   <= in_v;
            pm  <= (in_pm > 10'd1000) ? 10'd1000 : in_pm;
            idx <= '0;
            if (cmd == CMD_ADD) begin
              if (samples_seen == '0 || in_v < min_seen) min_seen <= in_v;
              if (in_v > max_seen) max_seen <= in_v;
              if (samples_seen != ONES) samples_seen <= samples_seen + 32'd1;
              sample_sum <= sample_sum + 64'(in_v);
            end else if (cmd == CMD_CLEAR) begin
              min_seen      <= ONES;
              max_seen      <= '0;
              samples_seen  <= '0;
              sample_sum    <= '0;
              overflow_seen <= '0;
            end
          end
        end
        ST_ADD_LOC: shf <= (s_raw > 5'd20) ? 5'd20 : s_raw;
        ST_ADD_RD: begin
          bidx <= is_lin ? AW'(v) : AW'(32'(LINEAR_BUCKETS) + gidx);
          if (ovf && overflow_seen != ONES) overflow_seen <= overflow_seen + 32'd1;
        end
        ST_Q_MUL: begin
          prod <= 42'(samples_seen) * 42'(pm);
          acc  <= '0;
          qv   <= '0;
          qe   <= 1'b0;
          qw   <= '0;
          mean <= '0;
        end
        ST_Q_TGT: target <= (prod == '0) ? 42'd1 : prod;
        ST_SCAN_CHK: begin
          acc <= acc_n;
          if (acc_n >= ACC_W'(target)) begin
            // idx holds the bucket
          end else if (idx == AW'(TOTAL - 1)) begin
            qv <= max_seen;
            qe <= 1'b0;
            qw <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_Q_BND: begin
          if (idx < AW'(LINEAR_BUCKETS)) begin
            qv <= 32'(idx);
            qe <= 1'b1;
            qw <= 8'd1;
          end else begin
            qv <= hi[31:0];
            qe <= (fs == '0);
            qw <= w64[7:0];
          end
        end
        ST_Q_MWAIT: begin
          if (drsp.done) begin
            mean <= (drsp.quotient[63:32] != '0) ? ONES : drsp.quotient[31:0];
          end
        end
        ST_Q_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {7'd0, overflow_seen, samples_seen, max_seen, min_seen,
                        mean, qw, qe, qv};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import llch_pkg::*;

  localparam int LIN = 64;
  localparam int GEO = 64;
  localparam int NB = LIN + GEO;
  localparam int N_RANDOM = 1500;
  localparam int WATCHDOG = 200000;
  localparam logic [31:0] ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] overflow_count;
    logic [31:0] sample_count;
    logic [31:0] max_ticks;
    logic [31:0] min_ticks;
    logic [31:0] mean_ticks;
    logic [7:0]  bucket_width;
    logic        exact;
    logic [31:0] quantile_value;
  } stats_t;

  typedef struct packed {
    logic [9:0]  permille;
    logic [31:0] ticks;
    cmd_t        cmd;
  } req_t;

  typedef struct {
    req_t   req;
    bit     typed;
    stats_t stats;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [207:0] m_tdata;

  log_linear_cost_histogram_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [31:0] hist [NB];
  logic [31:0] lo_seen, hi_seen, n_seen, n_over;
  logic [63:0] tick_sum;

  stats_t pending_stats [$];
  int mismatches = 0;
  int idle_run = 0;
  bit hold_rx = 0;
  bit no_idle = 0;
  bit done_tx = 0;
  row_t rows [$];

  function automatic logic [63:0] bucket_span(int g);
    int s;
    s = g / 8;
    if (s > 20) s = 20;
    return 64'd1 << s;
  endfunction

  function automatic int bucket_of(logic [31:0] v);
    logic [63:0] base;
    base = 64'(LIN);
    if (v < LIN) return int'(v);
    for (int g = 0; g < GEO; g++) begin
      if ({32'd0, v} < base + bucket_span(g)) return LIN + g;
      base += bucket_span(g);
    end
    return NB;
  endfunction

  task automatic wipe_stats();
    foreach (hist[i]) hist[i] = '0;
    lo_seen = ONES;
    hi_seen = '0;
    n_seen = '0;
    tick_sum = '0;
    n_over = '0;
  endtask

  function automatic stats_t summarise(logic [9:0] pm_in);
    stats_t r;
    logic [63:0] target, acc, lo, hi, q;
    logic [31:0] pm;
    bit found;
    r = '0;
    found = 0;
    if (n_seen != 0) begin
      pm = (pm_in > 1000) ? 32'd1000 : {22'd0, pm_in};
      target = ({32'd0, n_seen} * {32'd0, pm} + 64'd999) / 64'd1000;
      if (target == '0) target = 64'd1;
      acc = '0;
      for (int i = 0; i < NB && !found; i++) begin
        acc += {32'd0, hist[i]};
        if (acc >= target) begin
          if (i < LIN) begin
            lo = 64'(i);
            hi = 64'(i);
          end else begin
            lo = 64'(LIN);
            for (int g = 0; g < i - LIN; g++) lo += bucket_span(g);
            hi = lo + bucket_span(i - LIN) - 64'd1;
          end
          r.quantile_value = hi[31:0];
          r.exact = (hi == lo);
          r.bucket_width = 8'(hi - lo + 64'd1);
          found = 1;
        end
      end
      if (!found) r.quantile_value = hi_seen;
      q = tick_sum / {32'd0, n_seen};
      r.mean_ticks = (q > {32'd0, ONES}) ? ONES : q[31:0];
    end
    r.min_ticks = lo_seen;
    r.max_ticks = hi_seen;
    r.sample_count = n_seen;
    r.overflow_count = n_over;
    return r;
  endfunction

  task automatic apply_request(req_t q, bit typed, stats_t typed_stats);
    int b;
    stats_t s;
    case (q.cmd)
      CMD_ADD: begin
        if (n_seen == 0 || q.ticks < lo_seen) lo_seen = q.ticks;
        if (q.ticks > hi_seen) hi_seen = q.ticks;
        if (n_seen != ONES) n_seen++;
        tick_sum += {32'd0, q.ticks};
        b = bucket_of(q.ticks);
        if (b >= NB) begin
          if (n_over != ONES) n_over++;
        end else if (hist[b] != ONES) begin
          hist[b]++;
        end
      end
      CMD_QUERY: begin
        s = summarise(q.permille);
        if (typed && s != typed_stats) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row disagrees with predictor: expected %h actual %h",
                     typed_stats, s);
        end
        pending_stats.push_back(typed ? typed_stats : s);
      end
      CMD_CLEAR: wipe_stats();
      default: ;
    endcase
  endtask

  function automatic req_t mk(cmd_t c, logic [31:0] t, logic [9:0] p);
    req_t r;
    r.cmd = c;
    r.ticks = t;
    r.permille = p;
    return r;
  endfunction

  function automatic stats_t mk_stats(logic [31:0] qv, logic ex, logic [7:0] w,
                                      logic [31:0] mean, logic [31:0] mn,
                                      logic [31:0] mx, logic [31:0] n,
                                      logic [31:0] ov);
    stats_t s;
    s.quantile_value = qv;
    s.exact = ex;
    s.bucket_width = w;
    s.mean_ticks = mean;
    s.min_ticks = mn;
    s.max_ticks = mx;
    s.sample_count = n;
    s.overflow_count = ov;
    return s;
  endfunction

  task automatic add_row(req_t q, bit typed = 0, stats_t s = '0);
    row_t r;
    r.req = q;
    r.typed = typed;
    r.stats = s;
    rows.push_back(r);
  endtask

  function automatic req_t random_request();
    int k;
    logic [31:0] t;
    k = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0: t = $urandom_range(0, 63);
      1: t = $urandom_range(64, 2000);
      2: t = $urandom_range(2000, 200000);
      3: t = $urandom;
      4: t = ONES - $urandom_range(0, 3);
      default: t = $urandom_range(0, 600);
    endcase
    if (k < 70) return mk(CMD_ADD, t, 10'($urandom));
    if (k < 92) return mk(CMD_QUERY, $urandom, 10'($urandom));
    if (k < 96) return mk(CMD_CLEAR, $urandom, 10'($urandom));
    return mk(CMD_NONE, $urandom, 10'($urandom));
  endfunction

  task automatic send(req_t q, bit typed = 0, stats_t s = '0);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 7) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, q};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_request(q, typed, s);
  endtask

  // receiver
  always @(posedge clk) begin
    stats_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[200:0];
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h actual %h", want, got);
        end
      end
    end
    if (hold_rx) m_tready <= 1'b0;
    else if (no_idle) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 99) >= 7);
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wipe_stats();
    // directed table
    add_row(mk(CMD_QUERY, 0, 500), 1, mk_stats(0, 0, 0, 0, ONES, 0, 0, 0));
    add_row(mk(CMD_ADD, 0, 0));
    add_row(mk(CMD_QUERY, 0, 0), 1, mk_stats(0, 1, 1, 0, 0, 0, 1, 0));
    add_row(mk(CMD_ADD, ONES, 0));
    add_row(mk(CMD_QUERY, 0, 1000), 1, mk_stats(ONES, 0, 0, 32'h7FFF_FFFF, 0, ONES, 2, 1));
    add_row(mk(CMD_QUERY, 0, 1023), 1, mk_stats(ONES, 0, 0, 32'h7FFF_FFFF, 0, ONES, 2, 1));
    add_row(mk(CMD_QUERY, 0, 500));
    add_row(mk(CMD_NONE, 5, 5));
    add_row(mk(CMD_CLEAR, 0, 0));
    add_row(mk(CMD_QUERY, 0, 1), 1, mk_stats(0, 0, 0, 0, ONES, 0, 0, 0));
    add_row(mk(CMD_ADD, 63, 0));
    add_row(mk(CMD_ADD, 64, 0));
    add_row(mk(CMD_ADD, 71, 0));
    add_row(mk(CMD_ADD, 72, 0));
    add_row(mk(CMD_ADD, 1000, 0));
    add_row(mk(CMD_ADD, 32'h0010_0000, 0));
    add_row(mk(CMD_QUERY, 0, 0));
    add_row(mk(CMD_QUERY, 0, 333));
    add_row(mk(CMD_QUERY, 0, 667));
    add_row(mk(CMD_QUERY, 0, 999));
    add_row(mk(CMD_QUERY, 0, 1000));
    add_row(mk(CMD_ADD, 32'hAAAA_AAAA, 0));
    add_row(mk(CMD_ADD, 32'h5555_5555, 0));
    add_row(mk(CMD_QUERY, 0, 10'h3FF));
    add_row(mk(CMD_QUERY, 0, 10'h2AA));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].stats);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 400) no_idle = 1;
      if (n == 700) no_idle = 0;
      if (n == 900) begin
        hold_rx = 1;
        fork
          begin
            repeat (3000) @(posedge clk);
            hold_rx = 0;
          end
        join_none
      end
      if (n == 1200) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0) @(posedge clk);
      end
      send(random_request());
    end

    s_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/llch_pkg.sv
rtl/llch_div.sv
rtl/log_linear_cost_histogram_core.sv
verif/testbench.sv
